>>> rtl/lrr_pkg.sv
// ----------------------------------------------------------------------------
// Line and rectangle rasterizer package
// Shared constants, operation and register codes, and the small structs that
// travel between the rasterizer modules.
// ----------------------------------------------------------------------------
package lrr_pkg;

   localparam int COORD_BITS_DEFAULT = 12;
   localparam int CANVAS_BITS        = 11;
   localparam int RECT_BITS          = 11;

   localparam logic [CANVAS_BITS-1:0] CANVAS_WIDTH_RESET  = 11'd104;
   localparam logic [CANVAS_BITS-1:0] CANVAS_HEIGHT_RESET = 11'd212;

   // Edge number of the left edge, the final edge of a rectangle outline.
   localparam logic [1:0] SIDE_LAST = 2'd3;

   typedef enum logic [1:0] {
      OP_LINE = 2'd0,
      OP_RECT = 2'd1,
      OP_STEP = 2'd2
   } op_type;

   typedef enum logic {
      CSR_CANVAS_WIDTH  = 1'b0,
      CSR_CANVAS_HEIGHT = 1'b1
   } csr_index_type;

   typedef struct packed {
      logic [CANVAS_BITS-1:0] width;
      logic [CANVAS_BITS-1:0] height;
   } canvas_type;

   typedef struct packed {
      logic valid;
      logic on_canvas;
      logic last;
   } pixel_flags_type;

endpackage

>>> rtl/lrr_if.sv
// ----------------------------------------------------------------------------
// Line and rectangle rasterizer channels
// Valid/ready interfaces for the command, pixel and register write channels.
// ----------------------------------------------------------------------------
interface lrr_req_if
   import lrr_pkg::*;
#(
   parameter int COORD_BITS = COORD_BITS_DEFAULT
);
   logic                         valid;
   logic                         ready;
   logic [1:0]                   op;
   logic signed [COORD_BITS-1:0] start_x;
   logic signed [COORD_BITS-1:0] start_y;
   logic signed [COORD_BITS-1:0] end_x;
   logic signed [COORD_BITS-1:0] end_y;
   logic [RECT_BITS-1:0]         rect_width;
   logic [RECT_BITS-1:0]         rect_height;

   modport source (
      output valid, op, start_x, start_y, end_x, end_y, rect_width, rect_height,
      input  ready
   );
   modport sink (
      input  valid, op, start_x, start_y, end_x, end_y, rect_width, rect_height,
      output ready
   );
endinterface

interface lrr_rsp_if
   import lrr_pkg::*;
#(
   parameter int COORD_BITS = COORD_BITS_DEFAULT
);
   logic                         valid;
   logic                         ready;
   logic signed [COORD_BITS-1:0] pixel_x;
   logic signed [COORD_BITS-1:0] pixel_y;
   logic                         on_canvas;
   logic                         last;

   modport source (
      output valid, pixel_x, pixel_y, on_canvas, last,
      input  ready
   );
   modport sink (
      input  valid, pixel_x, pixel_y, on_canvas, last,
      output ready
   );
endinterface

interface lrr_csr_if
   import lrr_pkg::*;
();
   logic                   valid;
   logic                   ready;
   csr_index_type          reg_index;
   logic [CANVAS_BITS-1:0] data;

   modport source (
      output valid, reg_index, data,
      input  ready
   );
   modport sink (
      input  valid, reg_index, data,
      output ready
   );
endinterface

>>> rtl/lrr_csr.sv
// ----------------------------------------------------------------------------
// Canvas size registers
// Holds the canvas width and height used by the clip test.
// ----------------------------------------------------------------------------
module lrr_csr
   import lrr_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   lrr_csr_if.sink    csr_bus,
   output canvas_type canvas
);

   canvas_type canvas_ff;
   canvas_type canvas_in;

   assign csr_bus.ready = 1'b1;
   assign canvas        = canvas_ff;

   always_comb begin
      canvas_in = canvas_ff;
      if (csr_bus.valid) begin
         unique case (csr_bus.reg_index)
            CSR_CANVAS_WIDTH:  canvas_in.width  = csr_bus.data;
            CSR_CANVAS_HEIGHT: canvas_in.height = csr_bus.data;
            default:           canvas_in        = canvas_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         canvas_ff.width  <= CANVAS_WIDTH_RESET;
         canvas_ff.height <= CANVAS_HEIGHT_RESET;
      end else begin
         canvas_ff <= canvas_in;
      end
   end

endmodule

>>> rtl/lrr_engine.sv
// ----------------------------------------------------------------------------
// Rasterizer stepping engine
// Holds the Bresenham state of the current figure, loads lines and rectangle
// edges, and works out one pixel and the following state per step command.
// ----------------------------------------------------------------------------
module lrr_engine
   import lrr_pkg::*;
#(
   parameter int COORD_BITS = COORD_BITS_DEFAULT
)(
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         fire,
   input  logic [1:0]                   op,
   input  logic signed [COORD_BITS-1:0] start_x,
   input  logic signed [COORD_BITS-1:0] start_y,
   input  logic signed [COORD_BITS-1:0] end_x,
   input  logic signed [COORD_BITS-1:0] end_y,
   input  logic [RECT_BITS-1:0]         rect_width,
   input  logic [RECT_BITS-1:0]         rect_height,
   input  canvas_type                   canvas,
   output logic signed [COORD_BITS-1:0] pixel_x,
   output logic signed [COORD_BITS-1:0] pixel_y,
   output pixel_flags_type              flags
);

   localparam int C    = COORD_BITS;
   localparam int D    = C + 1;
   localparam int E    = C + 2;
   localparam int W2   = C + 3;
   localparam int WIDE = ((C > RECT_BITS) ? C : RECT_BITS) + 2;
   localparam int CMPW = (C > CANVAS_BITS) ? C : CANVAS_BITS;

   localparam logic signed [WIDE-1:0] COORD_MAX_W = WIDE'((2 ** (C - 1)) - 1);
   localparam logic signed [WIDE-1:0] COORD_MIN_W = WIDE'(-(2 ** (C - 1)));

   // Figure state.
   logic signed [C-1:0] cur_x_ff, cur_y_ff, goal_x_ff, goal_y_ff;
   logic signed [C-1:0] cur_x_in, cur_y_in, goal_x_in, goal_y_in;
   logic [D-1:0]        delta_x_ff, delta_y_ff, delta_x_in, delta_y_in;
   logic                step_x_neg_ff, step_y_neg_ff, step_x_neg_in, step_y_neg_in;
   logic signed [E-1:0] error_ff, error_in;
   logic                busy_ff, busy_in;
   logic                rect_mode_ff, rect_mode_in;
   logic [1:0]          side_ff, side_in;
   logic signed [C-1:0] left_ff, top_ff, right_ff, bottom_ff;
   logic signed [C-1:0] left_in, top_in, right_in, bottom_in;

   // Line loader.
   logic signed [C-1:0] ld_x1, ld_y1, ld_x2, ld_y2;
   logic signed [D-1:0] diff_x, diff_y;
   logic [D-1:0]        ld_dx, ld_dy;
   logic                ld_xneg, ld_yneg;
   logic signed [E-1:0] ld_err;

   // Rectangle corners and edge walk.
   logic signed [WIDE-1:0] sum_r, sum_b;
   logic signed [C-1:0]    right_new, bottom_new;
   logic [1:0]             side_from, side_to;
   logic signed [C-1:0]    side_x1, side_y1, side_x2, side_y2;

   // Step.
   logic                 at_goal, final_pixel, visible;
   logic signed [W2-1:0] e2, dx_w, dy_w, err_step;
   logic                 go_x, go_y;

   // Saturated right and bottom corners of a new rectangle.
   always_comb begin
      sum_r = WIDE'(start_x) + signed'(WIDE'(rect_width)) - WIDE'(1);
      sum_b = WIDE'(start_y) + signed'(WIDE'(rect_height)) - WIDE'(1);
      if (sum_r > COORD_MAX_W)      right_new = COORD_MAX_W[C-1:0];
      else if (sum_r < COORD_MIN_W) right_new = COORD_MIN_W[C-1:0];
      else                          right_new = sum_r[C-1:0];
      if (sum_b > COORD_MAX_W)      bottom_new = COORD_MAX_W[C-1:0];
      else if (sum_b < COORD_MIN_W) bottom_new = COORD_MIN_W[C-1:0];
      else                          bottom_new = sum_b[C-1:0];
   end

   // Next rectangle edge: corners go top-left, top-right, bottom-right,
   // bottom-left.
   always_comb begin
      side_from = side_ff + 2'd1;
      side_to   = side_ff + 2'd2;
      side_x1   = (side_from == 2'd1 || side_from == 2'd2) ? right_ff : left_ff;
      side_y1   = side_from[1] ? bottom_ff : top_ff;
      side_x2   = (side_to == 2'd1 || side_to == 2'd2) ? right_ff : left_ff;
      side_y2   = side_to[1] ? bottom_ff : top_ff;
   end

   // Endpoints for the shared line loader.
   always_comb begin
      unique case (op_type'(op))
         OP_LINE: begin
            ld_x1 = start_x;
            ld_y1 = start_y;
            ld_x2 = end_x;
            ld_y2 = end_y;
         end
         OP_RECT: begin
            ld_x1 = start_x;
            ld_y1 = start_y;
            ld_x2 = right_new;
            ld_y2 = start_y;
         end
         default: begin
            ld_x1 = side_x1;
            ld_y1 = side_y1;
            ld_x2 = side_x2;
            ld_y2 = side_y2;
         end
      endcase
   end

   always_comb begin
      diff_x  = D'(ld_x2) - D'(ld_x1);
      diff_y  = D'(ld_y2) - D'(ld_y1);
      ld_dx   = diff_x[D-1] ? D'(-diff_x) : D'(diff_x);
      ld_dy   = diff_y[D-1] ? D'(-diff_y) : D'(diff_y);
      ld_xneg = diff_x[D-1] || (diff_x == '0);
      ld_yneg = diff_y[D-1] || (diff_y == '0);
      ld_err  = signed'({1'b0, ld_dx}) - signed'({1'b0, ld_dy});
   end

   // Pixel, clip test and Bresenham step for the current position.
   always_comb begin
      at_goal     = (cur_x_ff == goal_x_ff) && (cur_y_ff == goal_y_ff);
      final_pixel = at_goal && (!rect_mode_ff || side_ff == SIDE_LAST);
      visible     = !cur_x_ff[C-1] && !cur_y_ff[C-1] &&
                    (CMPW'($unsigned(cur_x_ff)) < CMPW'(canvas.width)) &&
                    (CMPW'($unsigned(cur_y_ff)) < CMPW'(canvas.height));
      e2       = {error_ff, 1'b0};
      dx_w     = signed'(W2'(delta_x_ff));
      dy_w     = signed'(W2'(delta_y_ff));
      go_x     = e2 > -dy_w;
      go_y     = e2 < dx_w;
      err_step = W2'(error_ff) - (go_x ? dy_w : W2'(0)) + (go_y ? dx_w : W2'(0));
   end

   assign pixel_x = cur_x_ff;
   assign pixel_y = cur_y_ff;

   always_comb begin
      cur_x_in      = cur_x_ff;
      cur_y_in      = cur_y_ff;
      goal_x_in     = goal_x_ff;
      goal_y_in     = goal_y_ff;
      delta_x_in    = delta_x_ff;
      delta_y_in    = delta_y_ff;
      step_x_neg_in = step_x_neg_ff;
      step_y_neg_in = step_y_neg_ff;
      error_in      = error_ff;
      busy_in       = busy_ff;
      rect_mode_in  = rect_mode_ff;
      side_in       = side_ff;
      left_in       = left_ff;
      top_in        = top_ff;
      right_in      = right_ff;
      bottom_in     = bottom_ff;
      flags.valid     = 1'b0;
      flags.on_canvas = visible;
      flags.last      = final_pixel;

      if (fire) begin
         unique case (op_type'(op))
            OP_LINE, OP_RECT: begin
               cur_x_in      = ld_x1;
               cur_y_in      = ld_y1;
               goal_x_in     = ld_x2;
               goal_y_in     = ld_y2;
               delta_x_in    = ld_dx;
               delta_y_in    = ld_dy;
               step_x_neg_in = ld_xneg;
               step_y_neg_in = ld_yneg;
               error_in      = ld_err;
               busy_in       = 1'b1;
               side_in       = 2'd0;
               rect_mode_in  = (op_type'(op) == OP_RECT);
               if (op_type'(op) == OP_RECT) begin
                  left_in   = start_x;
                  top_in    = start_y;
                  right_in  = right_new;
                  bottom_in = bottom_new;
               end
            end
            OP_STEP: begin
               if (busy_ff) begin
                  flags.valid = 1'b1;
                  if (final_pixel) begin
                     busy_in = 1'b0;
                  end else if (at_goal) begin
                     cur_x_in      = ld_x1;
                     cur_y_in      = ld_y1;
                     goal_x_in     = ld_x2;
                     goal_y_in     = ld_y2;
                     delta_x_in    = ld_dx;
                     delta_y_in    = ld_dy;
                     step_x_neg_in = ld_xneg;
                     step_y_neg_in = ld_yneg;
                     error_in      = ld_err;
                     side_in       = side_from;
                  end else begin
                     error_in = err_step[E-1:0];
                     if (go_x) begin
                        cur_x_in = step_x_neg_ff ? cur_x_ff - C'(1) : cur_x_ff + C'(1);
                     end
                     if (go_y) begin
                        cur_y_in = step_y_neg_ff ? cur_y_ff - C'(1) : cur_y_ff + C'(1);
                     end
                  end
               end
            end
            default: begin
               busy_in = busy_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         rect_mode_ff <= 1'b0;
         side_ff      <= 2'd0;
      end else begin
         busy_ff      <= busy_in;
         rect_mode_ff <= rect_mode_in;
         side_ff      <= side_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_x_ff      <= cur_x_in;
      cur_y_ff      <= cur_y_in;
      goal_x_ff     <= goal_x_in;
      goal_y_ff     <= goal_y_in;
      delta_x_ff    <= delta_x_in;
      delta_y_ff    <= delta_y_in;
      step_x_neg_ff <= step_x_neg_in;
      step_y_neg_ff <= step_y_neg_in;
      error_ff      <= error_in;
      left_ff       <= left_in;
      top_ff        <= top_in;
      right_ff      <= right_in;
      bottom_ff     <= bottom_in;
   end

endmodule

>>> rtl/line_rect_rasterizer_core.sv
// ----------------------------------------------------------------------------
// Line and rectangle outline rasterizer
// Bresenham pixel stepper for lines and rectangle outlines with canvas clip.
// ----------------------------------------------------------------------------
// A start command (line or rectangle outline) loads a figure and returns no
// pixel; each later step command returns the next pixel of that figure with
// its on-canvas flag and a last flag on the figure's final pixel. Steps while
// no figure is loaded, and the unused op code, return nothing. The block takes
// one command per clock cycle unless stalled; the whole Bresenham update of
// one step is combinational from the state registers back into them, and a
// pixel appears on the result channel the cycle after its step command is
// taken. The command channel stalls only while a finished pixel is held in
// the output register and the result channel is not ready. Canvas size writes
// are always taken and must only be issued while the block is idle.
module line_rect_rasterizer_core
   import lrr_pkg::*;
#(
   parameter int COORD_BITS = COORD_BITS_DEFAULT
)(
   input  logic      clock,
   input  logic      reset,
   lrr_req_if.sink   req_bus,
   lrr_rsp_if.source rsp_bus,
   lrr_csr_if.sink   csr_bus
);

   canvas_type                   canvas;
   pixel_flags_type              flags;
   logic signed [COORD_BITS-1:0] pixel_x, pixel_y;
   logic                         fire;

   logic                         rsp_valid_ff, rsp_valid_in;
   logic signed [COORD_BITS-1:0] rsp_x_ff, rsp_y_ff;
   logic                         rsp_on_ff, rsp_last_ff;

   assign req_bus.ready = !rsp_valid_ff || rsp_bus.ready;
   assign fire          = req_bus.valid && req_bus.ready;

   lrr_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .csr_bus (csr_bus),
      .canvas  (canvas)
   );

   lrr_engine #(
      .COORD_BITS (COORD_BITS)
   ) u_engine (
      .clock       (clock),
      .reset       (reset),
      .fire        (fire),
      .op          (req_bus.op),
      .start_x     (req_bus.start_x),
      .start_y     (req_bus.start_y),
      .end_x       (req_bus.end_x),
      .end_y       (req_bus.end_y),
      .rect_width  (req_bus.rect_width),
      .rect_height (req_bus.rect_height),
      .canvas      (canvas),
      .pixel_x     (pixel_x),
      .pixel_y     (pixel_y),
      .flags       (flags)
   );

   always_comb begin
      if (fire) begin
         rsp_valid_in = flags.valid;
      end else if (rsp_bus.ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (fire && flags.valid) begin
         rsp_x_ff    <= pixel_x;
         rsp_y_ff    <= pixel_y;
         rsp_on_ff   <= flags.on_canvas;
         rsp_last_ff <= flags.last;
      end
   end

   assign rsp_bus.valid     = rsp_valid_ff;
   assign rsp_bus.pixel_x   = rsp_x_ff;
   assign rsp_bus.pixel_y   = rsp_y_ff;
   assign rsp_bus.on_canvas = rsp_on_ff;
   assign rsp_bus.last      = rsp_last_ff;

endmodule
